// ===== hw/rtl/sha384_pkg.sv =====
// Package: SHA-384 engine types, constants and round functions.
package sha384_pkg;

   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        last_word;
   } req_item_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_done;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      NXT_IDLE,
      NXT_LEN,
      NXT_OUT
   } after_type;

   localparam logic [63:0] INIT_HASH [8] = '{
      64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507,
      64'h9159015A3070DD17, 64'h152FECD8F70E5939,
      64'h67332667FFC00B31, 64'h8EB44A8768581511,
      64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4
   };

   localparam logic [63:0] ROUND_K [80] = '{
      64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
      64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
      64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
      64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
      64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
      64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
      64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
      64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
      64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
      64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
      64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
      64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
      64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
      64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
      64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
      64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
      64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
      64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
      64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
      64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
   };

   localparam logic [6:0] LAST_ROUND  = 7'd79;
   localparam logic [6:0] PAD_LIMIT   = 7'd112;
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [2:0] LAST_DIGEST = 3'd5;

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] big_sigma0(input logic [63:0] x);
      big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic logic [63:0] big_sigma1(input logic [63:0] x);
      big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic logic [63:0] small_sigma0(input logic [63:0] x);
      small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic logic [63:0] small_sigma1(input logic [63:0] x);
      small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

endpackage

// ===== hw/rtl/sha384_hash_engine.sv =====
// Top level: SHA-384 engine with one shared round unit under a small sequencer.
//
//   channel  direction  payload                         handshake
//   req_     in         data_word, byte_count, last     req_valid / req_stall
//   rsp_     out        digest_word, word_index, done   rsp_valid / rsp_stall
//
// A non-final item that does not fill the block is stored in the buffer; the 16th word
// of a block adds a compression (rounds, then a fold) on the shared round unit.
// A final item runs one or two compressions and then emits six digest items,
// one per cycle while rsp_stall is low.
// Synchronous active-high reset restores the initial hash and clears counts.
// req_stall is high whenever the sequencer is not idle.
module sha384_hash_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  sha384_pkg::req_item_type   req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sha384_pkg::rsp_item_type   rsp_item
);
   import sha384_pkg::*;

   state_type   state_ff, state_in;
   after_type   after_ff, after_in;
   logic [63:0] hash_ff [8];
   logic [63:0] blk_ff [16];
   logic [63:0] win_ff [16];
   logic [63:0] va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff, vh_ff;
   logic [3:0]  pos_ff;
   logic [127:0] bits_ff;
   logic [6:0]  round_ff;
   logic [2:0]  out_idx_ff;

   logic        take;
   logic [3:0]  cnt;
   logic [63:0] w_cur, t1, t2, mask, padded;
   logic [7:0]  used;

   assign take = req_valid && !req_stall;

   // Saturate count; a non-final item always counts as full.
   always_comb begin
      cnt = req_item.byte_count;
      if (!req_item.last_word || cnt > 4'd8) begin
         cnt = 4'd8;
      end
   end

   // Partial final word with padding byte below the valid bytes.
   always_comb begin
      mask   = (cnt == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {cnt[2:0], 3'b000});
      padded = (req_item.data_word & mask) | ({56'd0, PAD_BYTE} << (7'd56 - {cnt, 3'b000}));
      used   = {1'b0, pos_ff, 3'b000} + {4'd0, cnt} + 8'd1;
   end

   // Schedule word and round sums of the shared unit.
   always_comb begin
      if (round_ff < 7'd16) begin
         w_cur = blk_ff[round_ff[3:0]];
      end else begin
         w_cur = small_sigma1(win_ff[4'(round_ff - 7'd2)]) + win_ff[4'(round_ff - 7'd7)]
               + small_sigma0(win_ff[4'(round_ff - 7'd15)]) + win_ff[round_ff[3:0]];
      end
      t1 = vh_ff + big_sigma1(ve_ff) + ((ve_ff & vf_ff) ^ (~ve_ff & vg_ff))
         + ROUND_K[round_ff] + w_cur;
      t2 = big_sigma0(va_ff) + ((va_ff & vb_ff) ^ (va_ff & vc_ff) ^ (vb_ff & vc_ff));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && (req_item.last_word || (cnt == 4'd8 && pos_ff == 4'd15))) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            case (after_ff)
               NXT_LEN:  state_in = ST_ROUND;
               NXT_OUT:  state_in = ST_OUT;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (!rsp_stall && out_idx_ff == LAST_DIGEST) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_stall            = (state_ff != ST_IDLE);
      rsp_valid            = (state_ff == ST_OUT);
      rsp_item.digest_word = hash_ff[out_idx_ff];
      rsp_item.word_index  = out_idx_ff;
      rsp_item.digest_done = (out_idx_ff == LAST_DIGEST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control: fill position, bit count, round and digest counters, next step and hash state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         bits_ff    <= '0;
         round_ff   <= '0;
         out_idx_ff <= '0;
         after_ff   <= NXT_IDLE;
         for (int k = 0; k < 8; k++) begin
            hash_ff[k] <= INIT_HASH[k];
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  bits_ff <= bits_ff + {121'd0, cnt, 3'b000};
                  pos_ff  <= pos_ff + ((cnt == 4'd8) ? 4'd1 : 4'd0);
                  if (!req_item.last_word) begin
                     after_ff <= NXT_IDLE;
                  end else if (cnt == 4'd8 && pos_ff == 4'd15) begin
                     after_ff <= NXT_LEN;
                  end else if (used > {1'b0, PAD_LIMIT}) begin
                     after_ff <= NXT_LEN;
                  end else begin
                     after_ff <= NXT_OUT;
                  end
               end
            end
            ST_ROUND: begin
               round_ff <= round_ff + 7'd1;
            end
            ST_FOLD: begin
               round_ff <= '0;
               for (int k = 0; k < 8; k++) begin
                  hash_ff[k] <= hash_ff[k] + ((k == 0) ? va_ff : (k == 1) ? vb_ff :
                     (k == 2) ? vc_ff : (k == 3) ? vd_ff : (k == 4) ? ve_ff :
                     (k == 5) ? vf_ff : (k == 6) ? vg_ff : vh_ff);
               end
               if (after_ff == NXT_LEN) begin
                  after_ff <= NXT_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  if (out_idx_ff == LAST_DIGEST) begin
                     out_idx_ff <= '0;
                     pos_ff     <= '0;
                     bits_ff    <= '0;
                     for (int k = 0; k < 8; k++) begin
                        hash_ff[k] <= INIT_HASH[k];
                     end
                  end else begin
                     out_idx_ff <= out_idx_ff + 3'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Block buffer, schedule window and working variables.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (!req_item.last_word) begin
                  blk_ff[pos_ff] <= req_item.data_word;
               end else if (cnt == 4'd8) begin
                  blk_ff[pos_ff] <= req_item.data_word;
                  // Pad word goes after; a full block carries it to the next one.
                  for (int k = 0; k < 16; k++) begin
                     if (k > pos_ff) begin
                        blk_ff[k] <= (k == pos_ff + 1) ? {PAD_BYTE, 56'd0} : 64'd0;
                     end
                  end
                  if (pos_ff != 4'd15 && (used > {1'b0, PAD_LIMIT})) begin
                     // length cannot fit; handled at fold
                  end else if (pos_ff != 4'd15) begin
                     blk_ff[14] <= bits_ff[127:64] + {63'd0, (bits_ff[63:0] + 64'd64) < 64'd64};
                     blk_ff[15] <= bits_ff[63:0] + 64'd64;
                  end
               end else begin
                  for (int k = 0; k < 16; k++) begin
                     if (k == pos_ff) begin
                        blk_ff[k] <= padded;
                     end else if (k > pos_ff) begin
                        blk_ff[k] <= 64'd0;
                     end
                  end
                  if (used <= {1'b0, PAD_LIMIT}) begin
                     blk_ff[14] <= bits_ff[127:64]
                        + {63'd0, (bits_ff[63:0] + {57'd0, cnt, 3'b000}) < {57'd0, cnt, 3'b000}};
                     blk_ff[15] <= bits_ff[63:0] + {57'd0, cnt, 3'b000};
                  end
               end
               va_ff <= hash_ff[0]; vb_ff <= hash_ff[1]; vc_ff <= hash_ff[2];
               vd_ff <= hash_ff[3]; ve_ff <= hash_ff[4]; vf_ff <= hash_ff[5];
               vg_ff <= hash_ff[6]; vh_ff <= hash_ff[7];
            end
         end
         ST_ROUND: begin
            win_ff[round_ff[3:0]] <= w_cur;
            vh_ff <= vg_ff; vg_ff <= vf_ff; vf_ff <= ve_ff; ve_ff <= vd_ff + t1;
            vd_ff <= vc_ff; vc_ff <= vb_ff; vb_ff <= va_ff; va_ff <= t1 + t2;
         end
         ST_FOLD: begin
            // Length-only block: pad byte kept if the full block pushed it out.
            if (after_ff == NXT_LEN) begin
               for (int k = 0; k < 14; k++) begin
                  blk_ff[k] <= (k == 0 && pos_ff == 4'd0) ? {PAD_BYTE, 56'd0} : 64'd0;
               end
               blk_ff[14] <= bits_ff[127:64];
               blk_ff[15] <= bits_ff[63:0];
            end
            va_ff <= hash_ff[0] + va_ff; vb_ff <= hash_ff[1] + vb_ff;
            vc_ff <= hash_ff[2] + vc_ff; vd_ff <= hash_ff[3] + vd_ff;
            ve_ff <= hash_ff[4] + ve_ff; vf_ff <= hash_ff[5] + vf_ff;
            vg_ff <= hash_ff[6] + vg_ff; vh_ff <= hash_ff[7] + vh_ff;
         end
         default: ;
      endcase
   end

endmodule
